@@ rtl/ialu_pkg.sv @@
// shared types and constants for the integer alu with power and prime test
// no dependencies
package ialu_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int OPND_BITS     = 32;
   localparam int CMD_BITS      = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD   = 3'd0,
      CMD_SUB   = 3'd1,
      CMD_MUL   = 3'd2,
      CMD_DIV   = 3'd3,
      CMD_MOD   = 3'd4,
      CMD_POW   = 3'd5,
      CMD_DVS   = 3'd6,
      CMD_PRIME = 3'd7
   } cmd_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL_INIT,
      DP_MUL_STEP,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_PW_INIT,
      DP_PW_RES,
      DP_PW_BASE,
      DP_PR_DECIDE,
      DP_PR_NEXT,
      DP_FINISH
   } dp_op_type;

   // operand sources for the shared multiplier / divider
   typedef enum logic [1:0] {
      SEL_AB,
      SEL_RB,
      SEL_BB,
      SEL_XI
   } src_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL_RUN,
      ST_DIV_RUN,
      ST_PW_CHK,
      ST_PW_MR,
      ST_PW_MR_WB,
      ST_PW_MB,
      ST_PW_MB_WB,
      ST_PR_CHK,
      ST_PR_TEST,
      ST_PR_NEXT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      dp_op_type   op;
      src_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    cnt_last;
      logic    b_zero;
      logic    exp_zero;
      logic    exp_lsb;
      logic    pr_early;
      logic    pr_sq_gt;
      logic    rem_zero;
      logic    out_busy;
   } dp_status_type;

endpackage

@@ rtl/integer_alu_pow_prime_core.sv @@
// Integer ALU with power and primality test. One word in, one word out; one
// item is worked at a time. Multiply, divide, modulo and the divisibility test
// run on the one-bit-per-cycle shift-add multiplier and restoring divider.
// Power multiplies the result by the base for each set exponent bit and squares
// the base for every exponent bit. The prime test runs one division per odd trial
// divisor, up to sqrt(a)/2 trials. A finished result waits in the output
// register while the next word is taken. Depends on ialu_pkg, ialu_ctrl and
// ialu_dp.
module integer_alu_pow_prime_core #(
   parameter int WORD_BITS = ialu_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [2:0]  req_tuser,   // cmd [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // value [31:0], test_true [32], div_error [33]
);
   import ialu_pkg::*;

   dp_cmd_type    dcmd;
   dp_status_type sts;
   logic signed [OPND_BITS-1:0] value;
   logic test_true, div_error;

   ialu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .dcmd       (dcmd)
   );

   ialu_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .dcmd      (dcmd),
      .sts       (sts),
      .in_cmd    (req_tuser),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value),
      .out_tt    (test_true),
      .out_err   (div_error)
   );

   assign rsp_tdata = {6'b0, div_error, test_true, value};

   // a zero divisor always reports minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[31:0] == 32'hFFFF_FFFF)
      else $error("div_error without all-ones value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("test_true and div_error both set");

   // one word in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

endmodule

@@ rtl/ialu_ctrl.sv @@
// controller state machine for the integer alu
// depends on ialu_pkg; drives ialu_dp through command and status structs
module ialu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ialu_pkg::dp_status_type sts,
   output ialu_pkg::dp_cmd_type    dcmd
);
   import ialu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.cmd)
               CMD_ADD, CMD_SUB: state_in = ST_FINISH;
               CMD_MUL:          state_in = ST_MUL_RUN;
               CMD_POW:          state_in = ST_PW_CHK;
               CMD_PRIME:        state_in = ST_PR_CHK;
               default: begin
                  state_in = sts.b_zero ? ST_FINISH : ST_DIV_RUN;
               end
            endcase
         end
         ST_MUL_RUN: begin
            if (sts.cnt_last) state_in = ST_FINISH;
         end
         ST_DIV_RUN: begin
            if (sts.cnt_last) begin
               state_in = (sts.cmd == CMD_PRIME) ? ST_PR_TEST : ST_FINISH;
            end
         end
         ST_PW_CHK: begin
            if (sts.exp_zero)     state_in = ST_FINISH;
            else if (sts.exp_lsb) state_in = ST_PW_MR;
            else                  state_in = ST_PW_MB;
         end
         ST_PW_MR: begin
            if (sts.cnt_last) state_in = ST_PW_MR_WB;
         end
         ST_PW_MR_WB: state_in = ST_PW_MB;
         ST_PW_MB: begin
            if (sts.cnt_last) state_in = ST_PW_MB_WB;
         end
         ST_PW_MB_WB: state_in = ST_PW_CHK;
         ST_PR_CHK: begin
            state_in = (sts.pr_early || sts.pr_sq_gt) ? ST_FINISH : ST_DIV_RUN;
         end
         ST_PR_TEST: begin
            state_in = sts.rem_zero ? ST_FINISH : ST_PR_NEXT;
         end
         ST_PR_NEXT: state_in = ST_PR_CHK;
         ST_FINISH: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dcmd.op    = DP_NOP;
      dcmd.sel   = SEL_AB;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) dcmd.op = DP_LOAD;
         end
         ST_DISPATCH: begin
            case (sts.cmd)
               CMD_ADD, CMD_SUB: dcmd.op = DP_NOP;
               CMD_MUL:          dcmd.op = DP_MUL_INIT;
               CMD_POW:          dcmd.op = DP_PW_INIT;
               CMD_PRIME:        dcmd.op = DP_NOP;
               default: begin
                  if (!sts.b_zero) dcmd.op = DP_DIV_INIT;
               end
            endcase
         end
         ST_MUL_RUN, ST_PW_MR, ST_PW_MB: dcmd.op = DP_MUL_STEP;
         ST_DIV_RUN:                     dcmd.op = DP_DIV_STEP;
         ST_PW_CHK: begin
            if (!sts.exp_zero) begin
               dcmd.op  = DP_MUL_INIT;
               dcmd.sel = sts.exp_lsb ? SEL_RB : SEL_BB;
            end
         end
         ST_PW_MR_WB: dcmd.op = DP_PW_RES;
         ST_PW_MB_WB: dcmd.op = DP_PW_BASE;
         ST_PR_CHK: begin
            if (sts.pr_early || sts.pr_sq_gt) begin
               dcmd.op = DP_PR_DECIDE;
            end else begin
               dcmd.op  = DP_DIV_INIT;
               dcmd.sel = SEL_XI;
            end
         end
         ST_PR_NEXT: dcmd.op = DP_PR_NEXT;
         ST_FINISH: begin
            if (!sts.out_busy) dcmd.op = DP_FINISH;
         end
         default: dcmd.op = DP_NOP;
      endcase
   end

endmodule

@@ rtl/ialu_dp.sv @@
// datapath: operand registers, shift-add multiplier, restoring divider,
// power and trial-division registers and the result register; uses ialu_pkg
module ialu_dp #(
   parameter int WORD_BITS = ialu_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ialu_pkg::dp_cmd_type              dcmd,
   output ialu_pkg::dp_status_type           sts,
   input  logic [ialu_pkg::CMD_BITS-1:0]     in_cmd,
   input  logic signed [ialu_pkg::OPND_BITS-1:0] in_a,
   input  logic signed [ialu_pkg::OPND_BITS-1:0] in_b,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [ialu_pkg::OPND_BITS-1:0] out_value,
   output logic                              out_tt,
   output logic                              out_err
);
   import ialu_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(W);

   logic [W-1:0]  a_ff, b_ff, m_acc_ff, m_x_ff, m_y_ff;
   logic [W-1:0]  d_rem_ff, d_quo_ff, d_den_ff;
   logic [W-1:0]  res_ff, base_ff, exp_ff, pr_i_ff;
   logic [W:0]    pr_sq_ff;
   logic [CW-1:0] cnt_ff;
   cmd_type       cmd_ff;
   logic          tt_ff;
   logic          ovalid_ff;
   logic signed [OPND_BITS-1:0] oval_ff;
   logic          ott_ff, oerr_ff;

   logic          a_neg, b_neg, b_zero;
   logic [W-1:0]  ma, mb, d_t, d_sub;
   logic          d_ge;
   logic [W-1:0]  val_w;
   logic          fin_tt, fin_err;

   assign a_neg  = a_ff[W-1];
   assign b_neg  = b_ff[W-1];
   assign b_zero = (b_ff == '0);
   assign ma     = a_neg ? W'(-a_ff) : a_ff;
   assign mb     = b_neg ? W'(-b_ff) : b_ff;

   // one quotient bit per step
   assign d_t   = {d_rem_ff[W-2:0], d_quo_ff[W-1]};
   assign d_ge  = (d_t >= d_den_ff);
   assign d_sub = d_t - d_den_ff;

   assign sts.cmd      = cmd_ff;
   assign sts.cnt_last = (cnt_ff == '0);
   assign sts.b_zero   = b_zero;
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_lsb  = exp_ff[0];
   assign sts.pr_early = a_neg || (a_ff < W'(4)) || !a_ff[0];
   assign sts.pr_sq_gt = (pr_sq_ff > {1'b0, a_ff});
   assign sts.rem_zero = (d_rem_ff == '0);
   assign sts.out_busy = ovalid_ff && !out_ready;

   always_comb begin
      val_w   = '0;
      fin_tt  = 1'b0;
      fin_err = 1'b0;
      case (cmd_ff)
         CMD_ADD: val_w = a_ff + b_ff;
         CMD_SUB: val_w = a_ff - b_ff;
         CMD_MUL: val_w = m_acc_ff;
         CMD_DIV: begin
            fin_err = b_zero;
            if (b_zero)              val_w = '1;
            else if (a_neg != b_neg) val_w = W'(-d_quo_ff);
            else                     val_w = d_quo_ff;
         end
         CMD_MOD: begin
            fin_err = b_zero;
            if (b_zero)     val_w = '1;
            else if (a_neg) val_w = W'(-d_rem_ff);
            else            val_w = d_rem_ff;
         end
         CMD_DVS: begin
            fin_err = b_zero;
            val_w   = b_zero ? '1 : '0;
            fin_tt  = !b_zero && (d_rem_ff == '0);
         end
         CMD_POW: val_w = res_ff;
         CMD_PRIME: fin_tt = tt_ff;
         default: val_w = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (dcmd.op == DP_FINISH) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (dcmd.op)
         DP_LOAD: begin
            cmd_ff <= cmd_type'(in_cmd);
            a_ff   <= W'(in_a);
            b_ff   <= W'(in_b);
         end
         DP_MUL_INIT: begin
            m_acc_ff <= '0;
            cnt_ff   <= CW'(W - 1);
            case (dcmd.sel)
               SEL_RB: begin
                  m_x_ff <= res_ff;
                  m_y_ff <= base_ff;
               end
               SEL_BB: begin
                  m_x_ff <= base_ff;
                  m_y_ff <= base_ff;
               end
               default: begin
                  m_x_ff <= a_ff;
                  m_y_ff <= b_ff;
               end
            endcase
         end
         DP_MUL_STEP: begin
            if (m_y_ff[0]) m_acc_ff <= m_acc_ff + m_x_ff;
            m_x_ff <= {m_x_ff[W-2:0], 1'b0};
            m_y_ff <= {1'b0, m_y_ff[W-1:1]};
            cnt_ff <= cnt_ff - CW'(1);
         end
         DP_DIV_INIT: begin
            d_rem_ff <= '0;
            cnt_ff   <= CW'(W - 1);
            if (dcmd.sel == SEL_XI) begin
               d_quo_ff <= a_ff;
               d_den_ff <= pr_i_ff;
            end else begin
               d_quo_ff <= ma;
               d_den_ff <= mb;
            end
         end
         DP_DIV_STEP: begin
            d_rem_ff <= d_ge ? d_sub : d_t;
            d_quo_ff <= {d_quo_ff[W-2:0], d_ge};
            cnt_ff   <= cnt_ff - CW'(1);
         end
         DP_PW_INIT: begin
            base_ff <= a_ff;
            exp_ff  <= '0;
            if (a_ff == '0) begin
               res_ff <= '0;
            end else if (b_zero) begin
               res_ff <= W'(1);
            end else if (b_neg) begin
               if (a_ff == W'(1))   res_ff <= W'(1);
               else if (a_ff == '1) res_ff <= b_ff[0] ? '1 : W'(1);
               else                 res_ff <= '0;
            end else begin
               res_ff <= W'(1);
               exp_ff <= b_ff;
            end
         end
         DP_PW_RES: begin
            res_ff   <= m_acc_ff;
            // squaring of the base starts right away
            m_acc_ff <= '0;
            cnt_ff   <= CW'(W - 1);
            m_x_ff   <= base_ff;
            m_y_ff   <= base_ff;
         end
         DP_PW_BASE: begin
            base_ff <= m_acc_ff;
            exp_ff  <= {1'b0, exp_ff[W-1:1]};
         end
         DP_PR_DECIDE: begin
            tt_ff <= sts.pr_early ? (a_ff == W'(2) || a_ff == W'(3)) : 1'b1;
         end
         DP_PR_NEXT: begin
            pr_i_ff  <= pr_i_ff + W'(2);
            pr_sq_ff <= pr_sq_ff + (W+1)'({pr_i_ff, 2'b00}) + (W+1)'(4);
         end
         DP_FINISH: begin
            oval_ff <= OPND_BITS'($signed(val_w));
            ott_ff  <= fin_tt;
            oerr_ff <= fin_err;
         end
         default: begin
         end
      endcase
      // trial divisor restarts with every item
      if (dcmd.op == DP_LOAD) begin
         pr_i_ff  <= W'(3);
         pr_sq_ff <= (W+1)'(9);
         tt_ff    <= 1'b0;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_value = oval_ff;
   assign out_tt    = ott_ff;
   assign out_err   = oerr_ff;

endmodule

@@ bench/tb_top.sv @@
// testbench for the integer alu with power and primality test: directed and random
// words are checked against a predictor written in the bench. depends on ialu_pkg
// and integer_alu_pow_prime_core.
`timescale 1ns / 100ps

module tb_top;
   import ialu_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int HOLD_FROM   = 300;
   localparam int HOLD_LEN    = 500;

   class alu_scoreboard;
      bit [33:0] pending[$];
      int        errors = 0;

      function bit [31:0] pow_word(bit [31:0] a, bit [31:0] b);
         bit [31:0] r, base, e;
         if (a == 0) return 0;
         if (b == 0) return 1;
         if (b[31]) begin
            if (a == 1) return 1;
            if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
            return 0;
         end
         r = 1;
         base = a;
         e = b;
         while (e != 0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
         end
         return r;
      endfunction

      function bit is_prime(longint x);
         longint i;
         if (x < 2) return 0;
         if (x < 4) return 1;
         if (x[0] == 0) return 0;
         for (i = 3; i * i <= x; i += 2)
            if (x % i == 0) return 0;
         return 1;
      endfunction

      // work out value, test flag and divide error for one word
      function void note(cmd_type cmd, bit [31:0] a, bit [31:0] b);
         longint    sa, sb, ma, mb, q, r;
         bit [31:0] val;
         bit        tt, err;
         sa = longint'($signed(a));
         sb = longint'($signed(b));
         val = 0;
         tt = 0;
         err = 0;
         case (cmd)
            CMD_ADD: val = a + b;
            CMD_SUB: val = a - b;
            CMD_MUL: val = a * b;
            CMD_DIV, CMD_MOD, CMD_DVS: begin
               if (b == 0) begin
                  val = 32'hFFFF_FFFF;
                  err = 1;
               end else begin
                  ma = sa < 0 ? -sa : sa;
                  mb = sb < 0 ? -sb : sb;
                  q = ma / mb;
                  r = ma % mb;
                  if (cmd == CMD_DIV) val = 32'(((sa < 0) != (sb < 0)) ? -q : q);
                  else if (cmd == CMD_MOD) val = 32'((sa < 0) ? -r : r);
                  else tt = (r == 0);
               end
            end
            CMD_POW: val = pow_word(a, b);
            default: tt = is_prime(sa);
         endcase
         pending.push_back({err, tt, val});
      endfunction

      function void check(bit [39:0] got);
         bit [33:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got[31:0] !== want[31:0]) begin
            $display("%0t: value exp %h act %h", $time, want[31:0], got[31:0]);
            errors++;
         end
         if (got[32] !== want[32]) begin
            $display("%0t: test_true exp %b act %b", $time, want[32], got[32]);
            errors++;
         end
         if (got[33] !== want[33]) begin
            $display("%0t: div_error exp %b act %b", $time, want[33], got[33]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   alu_scoreboard sb = new();
   int cycles = 0;

   integer_alu_pow_prime_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: own stall pattern plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
      if (cycles >= HOLD_FROM && cycles < HOLD_FROM + HOLD_LEN) rsp_tready <= 0;
      else if ((cycles / 200) % 3 == 0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic send_word(cmd_type cmd, bit [31:0] a, bit [31:0] b);
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      sb.note(cmd, a, b);
   endtask

   task automatic idle_gap();
      int gap;
      if ($urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 20);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic bit [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return -$urandom_range(0, 20);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_word();
      cmd_type   cmd;
      bit [31:0] a, b;
      cmd = cmd_type'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (cmd == CMD_PRIME) begin
         // large values are made multiples of three or even, so the trial division ends early
         case ($urandom_range(0, 4))
            0: a = 3 * $urandom_range(1000000, 715827882);
            1: a = {1'($urandom_range(0, 1)), 30'($urandom), 1'b0};
            default: a = $urandom_range(0, 20000);
         endcase
      end
      send_word(cmd, a, b);
      idle_gap();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed corners
      send_word(CMD_ADD, 32'h7FFF_FFFF, 32'd1);
      send_word(CMD_SUB, 32'h8000_0000, 32'd1);
      send_word(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_MUL, 32'h1234_5678, 32'hFEDC_BA98);
      send_word(CMD_DIV, 32'd100, 32'd0);
      send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_DIV, -32'sd7, 32'd2);
      send_word(CMD_MOD, -32'sd7, 32'd2);
      send_word(CMD_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_MOD, 32'd5, 32'd0);
      send_word(CMD_DVS, 32'd12, 32'd0);
      send_word(CMD_DVS, -32'sd12, 32'd4);
      send_word(CMD_POW, 32'd0, 32'd0);
      send_word(CMD_POW, 32'd5, 32'd0);
      send_word(CMD_POW, 32'd1, -32'sd3);
      send_word(CMD_POW, 32'hFFFF_FFFF, -32'sd3);
      send_word(CMD_POW, 32'hFFFF_FFFF, 32'h8000_0000);
      send_word(CMD_POW, 32'd2, -32'sd1);
      send_word(CMD_POW, 32'd3, 32'h7FFF_FFFF);
      send_word(CMD_PRIME, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(CMD_PRIME, 32'd1, 32'd0);
      send_word(CMD_PRIME, 32'd2, 32'd0);
      send_word(CMD_PRIME, 32'd9, 32'd0);
      send_word(CMD_PRIME, 32'd65521, 32'd0);
      send_word(CMD_PRIME, 32'h7FFF_FFFD, 32'd0);
      repeat (600) random_word();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
